// File: hw/rtl/ycrgb_pkg.sv
package ycrgb_pkg;

    // Fixed-point formats
    localparam int COEF_FRACTION_BITS    = 10;
    localparam int CHANNEL_FRACTION_BITS = 8;
    localparam int MAX_PIXELS_LOG2       = 20;

    // Field and word widths
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int CH_W       = BYTE_W + CHANNEL_FRACTION_BITS;
    localparam int SUM_W      = BYTE_W + CHANNEL_FRACTION_BITS + MAX_PIXELS_LOG2;
    localparam int PC_W       = MAX_PIXELS_LOG2 + 1;
    localparam int CFG_DATA_W = PC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CNT_W      = $clog2(SUM_W);
    localparam int CF_W       = COEF_FRACTION_BITS + 3;
    localparam int RAW_W      = CF_W + 11;

    // Commands and result kinds
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_PIXEL  = 2'd0;
    localparam t_cmd CMD_REPORT = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STANDARD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'b1;

    // Q2.n coefficients, rounded half up from their decimal values
    localparam int COEF_ONE = 2 ** COEF_FRACTION_BITS;
    localparam logic signed [CF_W-1:0] K_LUMA    = CF_W'((1164 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_SD_CR_R = CF_W'((1596 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_SD_CR_G = CF_W'((813 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_SD_CB_G = CF_W'((391 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_SD_CB_B = CF_W'((2018 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_HD_CR_R = CF_W'((1793 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_HD_CR_G = CF_W'((534 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_HD_CB_G = CF_W'((213 * COEF_ONE + 500) / 1000);
    localparam logic signed [CF_W-1:0] K_HD_CB_B = CF_W'((2115 * COEF_ONE + 500) / 1000);

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mult;
        logic accum;
        logic clear;
        logic div_load;
        logic div_step;
        logic mean_store;
        logic out_load;
    } t_dp_ctl;

endpackage

// File: hw/rtl/ycrgb_ctrl.sv
module ycrgb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ycrgb_pkg::t_cmd    i_command,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ycrgb_pkg::t_dp_ctl o_ctl
);
    import ycrgb_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULT = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MEAN = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;
    t_dp_ctl          ctl;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_ctl       = ctl;

    // Sequence one transaction at a time
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        ctl     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    ctl.load_in = 1'b1;
                    case (i_command)
                        CMD_PIXEL: begin
                            n_state = ST_MULT;
                        end
                        CMD_REPORT: begin
                            ctl.div_load = 1'b1;
                            n_cnt        = CNT_W'(SUM_W - 1);
                            n_state      = ST_DIV;
                        end
                        CMD_CLEAR: begin
                            ctl.clear = 1'b1;
                            n_state   = ST_OUT;
                        end
                        default: begin
                            // drop unknown commands
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MULT: begin
                ctl.mult = 1'b1;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                ctl.accum = 1'b1;
                n_state   = ST_OUT;
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                n_cnt        = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                ctl.mean_store = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: drop on take, set on load
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hw/rtl/ycrgb_dp.sv
module ycrgb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ycrgb_pkg::t_dp_ctl                  i_ctl,
    input  logic                                i_cfg_we,
    input  logic [ycrgb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ycrgb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  ycrgb_pkg::t_cmd                     i_command,
    input  logic [ycrgb_pkg::BYTE_W-1:0]        i_luma,
    input  logic [ycrgb_pkg::BYTE_W-1:0]        i_chroma_blue,
    input  logic [ycrgb_pkg::BYTE_W-1:0]        i_chroma_red,
    output ycrgb_pkg::t_cmd                     o_result_kind,
    output logic [ycrgb_pkg::BYTE_W-1:0]        o_red_out,
    output logic [ycrgb_pkg::BYTE_W-1:0]        o_green_out,
    output logic [ycrgb_pkg::BYTE_W-1:0]        o_blue_out,
    output logic [ycrgb_pkg::WORD_W-1:0]        o_packed_mean,
    output logic [ycrgb_pkg::WORD_W-1:0]        o_display_word
);
    import ycrgb_pkg::*;

    localparam int CFB    = COEF_FRACTION_BITS;
    localparam int CHF    = CHANNEL_FRACTION_BITS;
    localparam int WIDE_W = BYTE_W + CFB + CHF;
    localparam int SHR    = (CFB >= CHF) ? CFB - CHF : 0;
    localparam int SHL    = (CFB >= CHF) ? 0 : CHF - CFB;
    localparam logic signed [RAW_W-1:0] TOP_RAW  = RAW_W'(255 * (2 ** CFB));
    localparam logic [WIDE_W-1:0]       TOP_WIDE = WIDE_W'(255 * (2 ** CFB));
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Clamp to 0..255.0 and move to the channel format
    function automatic logic [CH_W-1:0] to_channel(input logic signed [RAW_W-1:0] v);
        logic [WIDE_W-1:0] u;
        if (v[RAW_W-1]) begin
            u = '0;
        end else if (v > TOP_RAW) begin
            u = TOP_WIDE;
        end else begin
            u = WIDE_W'(v[CFB+BYTE_W-1:0]);
        end
        return CH_W'((u << SHL) >> SHR);
    endfunction

    logic                     r_std;
    logic [PC_W-1:0]          r_pixel_count;
    t_cmd                     r_kind;
    logic [BYTE_W-1:0]        r_y, r_cb, r_cr;
    logic signed [RAW_W-1:0]  r_raw [3];
    logic signed [RAW_W-1:0]  n_raw [3];
    logic [SUM_W-1:0]         r_sum [3];
    logic [SUM_W-1:0]         n_sum [3];
    logic [BYTE_W-1:0]        r_pix [3];
    logic [BYTE_W-1:0]        r_mean [3];
    logic [BYTE_W-1:0]        n_mean [3];
    logic [PC_W-1:0]          r_divisor;
    logic [SUM_W-1:0]         r_quo [3];
    logic [SUM_W-1:0]         n_quo [3];
    logic [PC_W-1:0]          r_rem [3];
    logic [PC_W-1:0]          n_rem [3];
    logic [CH_W-1:0]          chan [3];

    logic signed [8:0]        yv, cbv, crv;
    logic signed [CF_W-1:0]   k_cr_r, k_cr_g, k_cb_g, k_cb_b;
    logic signed [RAW_W-1:0]  p_base, p_cr_r, p_cr_g, p_cb_g, p_cb_b;
    logic [BYTE_W-1:0]        white;
    logic [WORD_W-1:0]        packed_word;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std         <= 1'b0;
            r_pixel_count <= PC_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STANDARD:    r_std         <= i_cfg_data[0];
                REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[PC_W-1:0];
                default:         r_std         <= r_std;
            endcase
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_kind <= i_command;
            r_y    <= i_luma;
            r_cb   <= i_chroma_blue;
            r_cr   <= i_chroma_red;
        end
    end

    // Multiply by the selected coefficients
    always_comb begin
        yv     = $signed({1'b0, r_y}) - 9'sd16;
        cbv    = $signed({1'b0, r_cb}) - 9'sd128;
        crv    = $signed({1'b0, r_cr}) - 9'sd128;
        k_cr_r = r_std ? K_HD_CR_R : K_SD_CR_R;
        k_cr_g = r_std ? K_HD_CR_G : K_SD_CR_G;
        k_cb_g = r_std ? K_HD_CB_G : K_SD_CB_G;
        k_cb_b = r_std ? K_HD_CB_B : K_SD_CB_B;
        p_base = RAW_W'(K_LUMA) * RAW_W'(yv);
        p_cr_r = RAW_W'(k_cr_r) * RAW_W'(crv);
        p_cr_g = RAW_W'(k_cr_g) * RAW_W'(crv);
        p_cb_g = RAW_W'(k_cb_g) * RAW_W'(cbv);
        p_cb_b = RAW_W'(k_cb_b) * RAW_W'(cbv);
        n_raw[CH_RED]   = p_base + p_cr_r;
        n_raw[CH_GREEN] = p_base - p_cr_g - p_cb_g;
        n_raw[CH_BLUE]  = p_base + p_cb_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mult) begin
            for (int c = 0; c < 3; c++) begin
                r_raw[c] <= n_raw[c];
            end
        end
    end

    // Clamp, saturating accumulate and divider step, one lane per channel
    always_comb begin
        logic [SUM_W:0]  s;
        logic [PC_W:0]   t;
        logic [PC_W:0]   diff;
        logic            ge;
        for (int c = 0; c < 3; c++) begin
            chan[c]  = to_channel(r_raw[c]);
            s        = {1'b0, r_sum[c]} + (SUM_W + 1)'(chan[c]);
            n_sum[c] = s[SUM_W] ? '1 : s[SUM_W-1:0];
            t        = {r_rem[c], r_quo[c][SUM_W-1]};
            diff     = t - {1'b0, r_divisor};
            ge       = (t >= {1'b0, r_divisor});
            n_rem[c] = ge ? diff[PC_W-1:0] : t[PC_W-1:0];
            n_quo[c] = {r_quo[c][SUM_W-2:0], ge};
            n_mean[c] = (|r_quo[c][SUM_W-1:CHF+BYTE_W]) ? '1 :
                        r_quo[c][CHF+BYTE_W-1:CHF];
        end
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_ctl.clear) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_ctl.accum) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= n_sum[c];
            end
        end
    end

    // Pixel bytes for the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.accum) begin
            for (int c = 0; c < 3; c++) begin
                r_pix[c] <= chan[c][CH_W-1 -: BYTE_W];
            end
        end
    end

    // Restoring divider, one quotient bit per cycle in each lane
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_load) begin
            r_divisor <= (r_pixel_count == '0) ? PC_W'(1) : r_pixel_count;
            for (int c = 0; c < 3; c++) begin
                r_quo[c] <= r_sum[c];
                r_rem[c] <= '0;
            end
        end else if (i_ctl.div_step) begin
            for (int c = 0; c < 3; c++) begin
                r_quo[c] <= n_quo[c];
                r_rem[c] <= n_rem[c];
            end
        end
    end

    // Means from the last report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_mean[c] <= '0;
            end
        end else if (i_ctl.mean_store) begin
            for (int c = 0; c < 3; c++) begin
                r_mean[c] <= n_mean[c];
            end
        end
    end

    // Whiteness and packed word
    always_comb begin
        white = (r_mean[CH_RED] < r_mean[CH_GREEN]) ? r_mean[CH_RED] : r_mean[CH_GREEN];
        if (r_mean[CH_BLUE] < white) begin
            white = r_mean[CH_BLUE];
        end
        packed_word = {white,
                       r_mean[CH_BLUE] - white,
                       r_mean[CH_GREEN] - white,
                       r_mean[CH_RED] - white};
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_result_kind  <= r_kind;
            o_red_out      <= (r_kind == CMD_PIXEL) ? r_pix[CH_RED] : '0;
            o_green_out    <= (r_kind == CMD_PIXEL) ? r_pix[CH_GREEN] : '0;
            o_blue_out     <= (r_kind == CMD_PIXEL) ? r_pix[CH_BLUE] : '0;
            o_packed_mean  <= (r_kind == CMD_REPORT) ? packed_word : '0;
            o_display_word <= {8'hFF, r_mean[CH_RED], r_mean[CH_GREEN], r_mean[CH_BLUE]};
        end
    end

endmodule

// File: hw/rtl/ycbcr_to_rgb_mean_whiteness_core.sv
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_stall      i_command, i_luma, i_chroma_blue,
//                                                  i_chroma_red
// out      output     o_out_valid / i_out_stall    o_result_kind, o_red_out, o_green_out,
//                                                  o_blue_out, o_packed_mean, o_display_word
// cfg      input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// One transaction at a time: a pixel passes the multiply, then clamp and accumulate, before
// it reaches the output register; a clear goes straight to it, and a report passes the restoring
// divider, which yields one quotient bit per cycle over the 36-bit sums, then the mean store. The
// next transaction is accepted in the cycle after the output register is loaded; a result that
// still waits in the output register under a stall holds the block back until it is taken.
// Reset is synchronous and active low; it clears sums, means and registers, no sweep.
// A stall on the output holds the result; o_in_stall is high whenever a transaction is
// in progress.
module ycbcr_to_rgb_mean_whiteness_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ycrgb_pkg::t_cmd                     i_command,
    input  logic [ycrgb_pkg::BYTE_W-1:0]        i_luma,
    input  logic [ycrgb_pkg::BYTE_W-1:0]        i_chroma_blue,
    input  logic [ycrgb_pkg::BYTE_W-1:0]        i_chroma_red,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ycrgb_pkg::t_cmd                     o_result_kind,
    output logic [ycrgb_pkg::BYTE_W-1:0]        o_red_out,
    output logic [ycrgb_pkg::BYTE_W-1:0]        o_green_out,
    output logic [ycrgb_pkg::BYTE_W-1:0]        o_blue_out,
    output logic [ycrgb_pkg::WORD_W-1:0]        o_packed_mean,
    output logic [ycrgb_pkg::WORD_W-1:0]        o_display_word,
    input  logic                                i_cfg_we,
    input  logic [ycrgb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ycrgb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ycrgb_pkg::*;

    t_dp_ctl ctl;

    // Sequence transactions
    ycrgb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    // Convert, accumulate and divide
    ycrgb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_luma         (i_luma),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_result_kind  (o_result_kind),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_packed_mean  (o_packed_mean),
        .o_display_word (o_display_word)
    );

endmodule

// File: test/ycbcr_to_rgb_mean_whiteness_core_tb.sv
`timescale 1ns / 1ps

module ycbcr_to_rgb_mean_whiteness_core_tb;
    import ycrgb_pkg::*;

    // Command code that the block must drop without a result
    localparam t_cmd CMD_UNKNOWN = 2'd3;

    localparam int  RANDOM_ITEMS = 400;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE       = 60;     // longer than a report takes
    localparam int  HOLD_CYCLES  = 200;

    // Q2.n conversion coefficients, rounded half up
    localparam longint Q_UNIT    = longint'(1) << COEF_FRACTION_BITS;
    localparam longint MUL_Y     = (1164 * Q_UNIT + 500) / 1000;
    localparam longint MUL_SD_R  = (1596 * Q_UNIT + 500) / 1000;
    localparam longint MUL_SD_GR = (813 * Q_UNIT + 500) / 1000;
    localparam longint MUL_SD_GB = (391 * Q_UNIT + 500) / 1000;
    localparam longint MUL_SD_B  = (2018 * Q_UNIT + 500) / 1000;
    localparam longint MUL_HD_R  = (1793 * Q_UNIT + 500) / 1000;
    localparam longint MUL_HD_GR = (534 * Q_UNIT + 500) / 1000;
    localparam longint MUL_HD_GB = (213 * Q_UNIT + 500) / 1000;
    localparam longint MUL_HD_B  = (2115 * Q_UNIT + 500) / 1000;
    localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;

    typedef struct {
        t_cmd              cmd;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] cr;
    } ycc_item_t;

    typedef struct {
        t_cmd              kind;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
        logic [WORD_W-1:0] mean_word;
        logic [WORD_W-1:0] disp_word;
    } rgb_result_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    t_cmd                  i_command      = CMD_PIXEL;
    logic [BYTE_W-1:0]     i_luma         = '0;
    logic [BYTE_W-1:0]     i_chroma_blue  = '0;
    logic [BYTE_W-1:0]     i_chroma_red   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    t_cmd                  o_result_kind;
    logic [BYTE_W-1:0]     o_red_out;
    logic [BYTE_W-1:0]     o_green_out;
    logic [BYTE_W-1:0]     o_blue_out;
    logic [WORD_W-1:0]     o_packed_mean;
    logic [WORD_W-1:0]     o_display_word;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Pixel stream waiting to be offered, and results still owed by the block
    ycc_item_t   ycc_items[$];
    rgb_result_t rgb_due[$];

    // Shadow of the block's registers and colour statistics
    logic              std_hd;
    logic [PC_W-1:0]   pixel_div;
    longint unsigned   sum_r, sum_g, sum_b;
    logic [BYTE_W-1:0] mean_r, mean_g, mean_b;

    logic calm = 1'b0;
    int   mismatches = 0;
    int   items_queued = 0;
    int   cycles = 0;

    ycbcr_to_rgb_mean_whiteness_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_luma         (i_luma),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_packed_mean  (o_packed_mean),
        .o_display_word (o_display_word),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Clamp a channel with n fraction bits (the Q2.n coefficient scale) to 0..255 and rescale it to 8.m fixed point
    function automatic longint unsigned channel_fix(longint v);
        longint top;
        top = 255 * Q_UNIT;
        if (v < 0) v = 0;
        if (v > top) v = top;
        if (COEF_FRACTION_BITS >= CHANNEL_FRACTION_BITS)
            return longint'(v) >> (COEF_FRACTION_BITS - CHANNEL_FRACTION_BITS);
        return longint'(v) << (CHANNEL_FRACTION_BITS - COEF_FRACTION_BITS);
    endfunction

    function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned x);
        longint unsigned s;
        s = acc + x;
        return (s > SUM_LIMIT) ? SUM_LIMIT : s;
    endfunction

    function automatic logic [BYTE_W-1:0] byte_avg(longint unsigned acc, longint unsigned div);
        longint unsigned q;
        q = (acc / div) >> CHANNEL_FRACTION_BITS;
        return (q > 255) ? 8'd255 : q[BYTE_W-1:0];
    endfunction

    // Work out what one accepted transaction returns and update the statistics
    task automatic track_item(input ycc_item_t it);
        rgb_result_t     res;
        longint          yv, cbv, crv, base;
        longint unsigned rc, gc, bc, div;
        logic [BYTE_W-1:0] w;
        res = '{kind: it.cmd, r: '0, g: '0, b: '0, mean_word: '0, disp_word: '0};
        case (it.cmd)
            CMD_PIXEL: begin
                yv   = longint'(it.y) - 16;
                cbv  = longint'(it.cb) - 128;
                crv  = longint'(it.cr) - 128;
                base = MUL_Y * yv;
                if (std_hd) begin
                    rc = channel_fix(base + MUL_HD_R * crv);
                    gc = channel_fix(base - MUL_HD_GR * crv - MUL_HD_GB * cbv);
                    bc = channel_fix(base + MUL_HD_B * cbv);
                end else begin
                    rc = channel_fix(base + MUL_SD_R * crv);
                    gc = channel_fix(base - MUL_SD_GR * crv - MUL_SD_GB * cbv);
                    bc = channel_fix(base + MUL_SD_B * cbv);
                end
                sum_r = sat_sum(sum_r, rc);
                sum_g = sat_sum(sum_g, gc);
                sum_b = sat_sum(sum_b, bc);
                res.r = BYTE_W'(rc >> CHANNEL_FRACTION_BITS);
                res.g = BYTE_W'(gc >> CHANNEL_FRACTION_BITS);
                res.b = BYTE_W'(bc >> CHANNEL_FRACTION_BITS);
            end
            CMD_REPORT: begin
                div    = (pixel_div == 0) ? 1 : longint'(pixel_div);
                mean_r = byte_avg(sum_r, div);
                mean_g = byte_avg(sum_g, div);
                mean_b = byte_avg(sum_b, div);
                w = (mean_r < mean_g) ? mean_r : mean_g;
                if (mean_b < w) w = mean_b;
                res.mean_word = {w, mean_b - w, mean_g - w, mean_r - w};
            end
            CMD_CLEAR: begin
                sum_r = 0;
                sum_g = 0;
                sum_b = 0;
            end
            default: return;
        endcase
        res.disp_word = {8'hFF, mean_r, mean_g, mean_b};
        rgb_due.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Offer queued transactions, holding each one until it is taken
    always @(posedge i_clk) begin : driver
        logic fire;
        ycc_item_t cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire)
                track_item(cur);
            if (!i_in_valid || fire) begin
                if (ycc_items.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
                    cur = ycc_items.pop_front();
                    i_command     <= cur.cmd;
                    i_luma        <= cur.y;
                    i_chroma_blue <= cur.cb;
                    i_chroma_red  <= cur.cr;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each taken result; now and then hold the output off for a long stretch
    always @(posedge i_clk) begin : monitor
        int hold_left;
        int taken;
        rgb_result_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            taken = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (rgb_due.size() == 0) begin
                    $error("result of kind %0d with nothing outstanding", o_result_kind);
                    mismatches++;
                end else begin
                    want = rgb_due.pop_front();
                    check_field("result_kind", WORD_W'(want.kind), WORD_W'(o_result_kind));
                    check_field("red_out", WORD_W'(want.r), WORD_W'(o_red_out));
                    check_field("green_out", WORD_W'(want.g), WORD_W'(o_green_out));
                    check_field("blue_out", WORD_W'(want.b), WORD_W'(o_blue_out));
                    check_field("packed_mean", want.mean_word, o_packed_mean);
                    check_field("display_word", want.disp_word, o_display_word);
                end
                taken++;
                if (taken % 150 == 0)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 30);
            end
        end
    end

    // Give up on a hung block
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_item(input t_cmd cmd, input logic [7:0] y, input logic [7:0] cb,
                              input logic [7:0] cr);
        ycc_items.push_back('{cmd: cmd, y: y, cb: cb, cr: cr});
        if (cmd != CMD_UNKNOWN)
            items_queued++;
    endtask

    task automatic queue_random(input t_cmd cmd);
        queue_item(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    endtask

    // Hold back until every queued transaction is taken and every result is in
    task automatic wait_idle();
        while (ycc_items.size() != 0 || rgb_due.size() != 0 || i_in_valid)
            @(negedge i_clk);
    endtask

    // Write a register once the block has drained, including any dropped command
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_STANDARD:    std_hd = data[0];
            REG_PIXEL_COUNT: pixel_div = data[PC_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int n, pc, sel, phase;
        std_hd    = 1'b0;
        pixel_div = PC_W'(1);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        mean_r = '0;
        mean_g = '0;
        mean_b = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // SDTV, divide by one: black, white, clamping both ways, saturated means
        queue_item(CMD_PIXEL, 8'd16, 8'd128, 8'd128);
        queue_item(CMD_PIXEL, 8'd235, 8'd128, 8'd128);
        queue_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
        queue_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0);
        queue_item(CMD_PIXEL, 8'd128, 8'd255, 8'd0);
        queue_item(CMD_REPORT, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_UNKNOWN, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_CLEAR, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_REPORT, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_PIXEL, 8'd81, 8'd90, 8'd240);
        queue_item(CMD_REPORT, 8'd0, 8'd0, 8'd0);

        // HDTV with a zero count, which must divide by one
        write_reg(REG_STANDARD, CFG_DATA_W'(1));
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(0));
        queue_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_PIXEL, 8'd145, 8'd54, 8'd34);
        queue_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_PIXEL, 8'd0, 8'd128, 8'd128);
        queue_item(CMD_REPORT, 8'd0, 8'd0, 8'd0);

        // Widest counts: the means collapse to zero, clear keeps them
        write_reg(REG_PIXEL_COUNT, {CFG_DATA_W{1'b1}});
        queue_item(CMD_REPORT, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_PIXEL, 8'd200, 8'd100, 8'd170);
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(1 << MAX_PIXELS_LOG2));
        queue_item(CMD_REPORT, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_REPORT, 8'd0, 8'd0, 8'd0);

        // Random frames: clear, a frame of pixels, report, with some noise
        n = items_queued + RANDOM_ITEMS;
        phase = 0;
        while (items_queued < n) begin
            sel = $urandom_range(9);
            pc = (sel == 0) ? 0 :
                 (sel == 1) ? (1 << MAX_PIXELS_LOG2) :
                 (sel == 2) ? (1 << PC_W) - 1 : $urandom_range(1, 24);
            write_reg(REG_STANDARD, CFG_DATA_W'($urandom_range(1)));
            write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(pc));
            calm = (phase == 3);
            repeat ($urandom_range(3, 6)) begin
                if ($urandom_range(3) != 0)
                    queue_random(CMD_CLEAR);
                sel = (pc >= 1 && pc <= 24) ? pc : $urandom_range(1, 24);
                if ($urandom_range(4) == 0)
                    sel = $urandom_range(1, 40);
                repeat (sel) begin
                    queue_random(CMD_PIXEL);
                    if ($urandom_range(19) == 0)
                        queue_random(t_cmd'($urandom_range(3)));
                end
                queue_random(CMD_REPORT);
            end
            wait_idle();
            phase++;
        end
        calm = 1'b0;

        // Drain and give the block time to show any stray result
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
